[rtl/core/lav_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg: shared types and helpers of the look-at view matrix block
// Holds the fixed-point word types, the queued item layout and the
// saturation helper that the front and back parts both use.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Three Q-format components, index 0 is x.
  typedef logic [2:0][DATA_W-1:0] vec3_t;

  // One queued item: the eye, the up hint and the saturated eye-minus-target.
  typedef struct packed {
    vec3_t eye;
    vec3_t up;
    vec3_t fwd;
  } item_t;

  // Clamp a 64-bit signed value into the 32-bit signed range.
  function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic [DATA_W-1:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r = 32'h7fff_ffff;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Successor of a component index, wrapping after z.
  function automatic logic [1:0] next_axis(input logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

endpackage

[rtl/core/lav_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_if: channel interfaces of the look-at view matrix block
// lav_in_if carries one camera description, lav_out_if one matrix column
// group. A transaction completes when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lav_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] look_x;
  logic signed [31:0] look_y;
  logic signed [31:0] look_z;
  logic signed [31:0] up_x;
  logic signed [31:0] up_y;
  logic signed [31:0] up_z;

  modport source (output valid, eye_x, eye_y, eye_z, look_x, look_y, look_z,
                  up_x, up_y, up_z, input ready);
  modport sink   (input valid, eye_x, eye_y, eye_z, look_x, look_y, look_z,
                  up_x, up_y, up_z, output ready);
endinterface

interface lav_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         column_index;
  logic signed [31:0] elem0;
  logic signed [31:0] elem1;
  logic signed [31:0] elem2;
  logic signed [31:0] elem3;
  logic               final_group;

  modport source (output valid, column_index, elem0, elem1, elem2, elem3,
                  final_group, input ready);
  modport sink   (input valid, column_index, elem0, elem1, elem2, elem3,
                  final_group, output ready);
endinterface

[rtl/core/lav_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_front: input side of the look-at view matrix block
// Accepts camera transactions, forms the saturated eye-minus-target vector
// and holds the items in a short queue until the back part takes them.
// ----------------------------------------------------------------------------
module lav_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  lav_in_if.sink         in_i,
  output lav_pkg::item_t item_o,
  output logic           item_valid_o,
  input  logic           item_pop_i
);
  import lav_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  item_t            queue_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;
  item_t            item_in;

  function automatic logic [DATA_W-1:0] sat_diff(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic signed [DATA_W:0] d;
    d = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
    return sat32(64'(d));
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    item_in.eye = {in_i.eye_z, in_i.eye_y, in_i.eye_x};
    item_in.up  = {in_i.up_z, in_i.up_y, in_i.up_x};
    item_in.fwd = {sat_diff(in_i.eye_z, in_i.look_z),
                   sat_diff(in_i.eye_y, in_i.look_y),
                   sat_diff(in_i.eye_x, in_i.look_x)};
  end

  assign in_i.ready   = (cnt_q != CW'(QUEUE_DEPTH));
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

[rtl/core/lav_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_sqrt: iterative integer square root
// Produces the floor square root of a 64-bit unsigned value, one result
// bit per cycle.
// ----------------------------------------------------------------------------
module lav_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] rem_sh, trial;
  logic        ge;

  assign rem_sh = {rem_q, rad_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= ge ? 34'(rem_sh - trial) : 34'(rem_sh);
      root_q <= {root_q[30:0], ge};
    end
  end

endmodule

[rtl/core/lav_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_div: iterative unsigned divider
// Divides a magnitude scaled by the fraction bits by a 32-bit length,
// restoring one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module lav_div #(
  parameter int unsigned FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [31:0]             mag_i,
  input  logic [31:0]             den_i,
  output logic                    done_o,
  output logic [32+FRAC_BITS-1:0] quo_o
);

  localparam int unsigned QW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(QW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [QW-1:0] num_q;
  logic [31:0]   rem_q, den_q;
  logic [32:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q, num_q[QW-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {mag_i, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= {num_q[QW-2:0], ge};
      rem_q <= ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
    end
  end

endmodule

[rtl/core/lav_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_back: execution side of the look-at view matrix block
// Sequences one item through a shared multiply-accumulate pipe, the square
// root unit and the divider, then drives the four column groups out.
// ----------------------------------------------------------------------------
module lav_back #(
  parameter int unsigned FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lav_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_pop_o,
  lav_out_if.source      out_o
);
  import lav_pkg::*;

  localparam int unsigned QW = 32 + FRAC_BITS;

  localparam logic [3:0] P_IDLE    = 4'd0;
  localparam logic [3:0] P_SQ      = 4'd1;
  localparam logic [3:0] P_SQRT    = 4'd2;
  localparam logic [3:0] P_DIV     = 4'd3;
  localparam logic [3:0] P_CROSS_S = 4'd4;
  localparam logic [3:0] P_CROSS_U = 4'd5;
  localparam logic [3:0] P_DOT     = 4'd6;
  localparam logic [3:0] P_OUT     = 4'd7;

  typedef struct packed {
    logic       vld;
    logic       sq;
    logic       first;
    logic       last;
    logic       neg;
    logic [1:0] dest;
  } mtag_t;

  logic [3:0]  phase_q;
  logic        nsel_q, run_q;
  logic [3:0]  idx_q, n_ops;
  logic [1:0]  comp_q, grp_q;
  vec3_t       eye_q, up_q, f_q, s_q, u_q, t_q;
  vec3_t       vsel, cra, crb;
  logic [31:0] len_q;

  // Multiply-accumulate pipe.
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod_q, acc_q, acc_d, pmag;
  logic [63:0]        mag_q, sumsq_q;
  logic               sgn_q;
  mtag_t              tag_n, tag1_q, tag2_q;
  logic               issue, retire;
  logic [1:0]         c, p, q, row, col;

  // Iterative units.
  logic          sq_start, sq_done, dv_start, dv_done;
  logic [31:0]   sq_root, dv_mag;
  logic [QW-1:0] dv_quo;
  logic [31:0]   dv_res;
  logic          dv_neg;

  // Output register.
  logic        ov_q, ofin_q, load;
  logic [1:0]  ocol_q;
  logic [31:0] oe0_q, oe1_q, oe2_q, oe3_q;

  assign vsel = nsel_q ? s_q : f_q;
  assign cra  = (phase_q == P_CROSS_S) ? up_q : f_q;
  assign crb  = (phase_q == P_CROSS_S) ? f_q : s_q;

  always_comb begin
    unique case (phase_q)
      P_SQ:                n_ops = 4'd3;
      P_CROSS_S, P_CROSS_U: n_ops = 4'd6;
      P_DOT:               n_ops = 4'd9;
      default:             n_ops = 4'd0;
    endcase
  end

  assign issue = (idx_q < n_ops);

  always_comb begin
    unique case (idx_q)
      4'd0, 4'd1, 4'd2: row = 2'd0;
      4'd3, 4'd4, 4'd5: row = 2'd1;
      default:          row = 2'd2;
    endcase
    unique case (idx_q)
      4'd0, 4'd3, 4'd6: col = 2'd0;
      4'd1, 4'd4, 4'd7: col = 2'd1;
      default:          col = 2'd2;
    endcase
  end

  always_comb begin
    c     = idx_q[2:1];
    p     = next_axis(c);
    q     = next_axis(p);
    opa   = '0;
    opb   = '0;
    tag_n = '0;
    if (phase_q == P_SQ) begin
      opa        = $signed(vsel[idx_q[1:0]]);
      opb        = $signed(vsel[idx_q[1:0]]);
      tag_n.sq   = 1'b1;
      tag_n.first = (idx_q == 4'd0);
      tag_n.last  = (idx_q == 4'd2);
    end else if (phase_q == P_DOT) begin
      unique case (row)
        2'd0:    opa = $signed(s_q[col]);
        2'd1:    opa = $signed(u_q[col]);
        default: opa = $signed(f_q[col]);
      endcase
      opb         = $signed(eye_q[col]);
      tag_n.neg   = 1'b1;
      tag_n.first = (col == 2'd0);
      tag_n.last  = (col == 2'd2);
      tag_n.dest  = row;
    end else begin
      // Cross product: each component is two products, the second subtracted.
      if (!idx_q[0]) begin
        opa = $signed(cra[p]);
        opb = $signed(crb[q]);
      end else begin
        opa = $signed(cra[q]);
        opb = $signed(crb[p]);
      end
      tag_n.neg   = idx_q[0];
      tag_n.first = !idx_q[0];
      tag_n.last  = idx_q[0];
      tag_n.dest  = c;
    end
    tag_n.vld = issue;
  end

  assign pmag   = prod_q[63] ? -prod_q : prod_q;
  assign acc_d  = (tag2_q.first ? 64'sd0 : acc_q) +
                  (sgn_q ? -$signed(mag_q) : $signed(mag_q));
  assign retire = tag2_q.vld && tag2_q.last && (tag2_q.sq || tag2_q.dest == 2'd2);

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    if (tag1_q.sq) begin
      mag_q <= prod_q;
    end else begin
      mag_q <= pmag >> FRAC_BITS;
    end
    sgn_q <= prod_q[63] ^ tag1_q.neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_n;
      tag2_q <= tag1_q;
    end
  end

  // Square root and divide, shared by both normalizations.
  assign sq_start = (phase_q == P_SQRT) && !run_q;
  assign dv_start = (phase_q == P_DIV) && !run_q;
  assign dv_mag   = vsel[comp_q][31] ? 32'(-vsel[comp_q]) : vsel[comp_q];
  assign dv_neg   = vsel[comp_q][31];

  always_comb begin
    if (dv_neg) begin
      dv_res = (dv_quo >= QW'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-dv_quo[31:0]);
    end else begin
      dv_res = (dv_quo > QW'(64'h7fff_ffff)) ? 32'h7fff_ffff : dv_quo[31:0];
    end
  end

  lav_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sumsq_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  lav_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .mag_i   (dv_mag),
    .den_i   (len_q),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  assign item_pop_o = (phase_q == P_IDLE) && item_valid_i;
  assign load       = (phase_q == P_OUT) && (!ov_q || out_o.ready);

  // Sequencer and result vectors.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      nsel_q  <= 1'b0;
      run_q   <= 1'b0;
      idx_q   <= '0;
      comp_q  <= '0;
      grp_q   <= '0;
    end else begin
      if (issue) begin
        idx_q <= idx_q + 4'd1;
      end
      unique case (phase_q)
        P_IDLE: begin
          if (item_valid_i) begin
            phase_q <= P_SQ;
            nsel_q  <= 1'b0;
            idx_q   <= '0;
          end
        end
        P_SQ: begin
          if (retire) begin
            phase_q <= P_SQRT;
          end
        end
        P_SQRT: begin
          if (sq_start) begin
            run_q <= 1'b1;
          end else if (sq_done) begin
            run_q  <= 1'b0;
            comp_q <= '0;
            idx_q  <= '0;
            if (sq_root == '0) begin
              phase_q <= nsel_q ? P_CROSS_U : P_CROSS_S;
            end else begin
              phase_q <= P_DIV;
            end
          end
        end
        P_DIV: begin
          if (dv_start) begin
            run_q <= 1'b1;
          end else if (dv_done) begin
            run_q  <= 1'b0;
            comp_q <= comp_q + 2'd1;
            if (comp_q == 2'd2) begin
              phase_q <= nsel_q ? P_CROSS_U : P_CROSS_S;
              idx_q   <= '0;
            end
          end
        end
        P_CROSS_S: begin
          if (retire) begin
            phase_q <= P_SQ;
            nsel_q  <= 1'b1;
            idx_q   <= '0;
          end
        end
        P_CROSS_U: begin
          if (retire) begin
            phase_q <= P_DOT;
            idx_q   <= '0;
          end
        end
        P_DOT: begin
          if (retire) begin
            phase_q <= P_OUT;
            grp_q   <= '0;
          end
        end
        P_OUT: begin
          if (load) begin
            grp_q <= grp_q + 2'd1;
            if (grp_q == 2'd3) begin
              phase_q <= P_IDLE;
            end
          end
        end
        default: phase_q <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      eye_q <= item_i.eye;
      up_q  <= item_i.up;
      f_q   <= item_i.fwd;
    end
    if (phase_q == P_SQRT && sq_done) begin
      len_q <= sq_root;
    end
    if (phase_q == P_DIV && dv_done) begin
      if (nsel_q) begin
        s_q[comp_q] <= dv_res;
      end else begin
        f_q[comp_q] <= dv_res;
      end
    end
    if (tag2_q.vld) begin
      if (tag2_q.sq) begin
        sumsq_q <= (tag2_q.first ? 64'd0 : sumsq_q) + mag_q;
      end else begin
        acc_q <= acc_d;
        if (tag2_q.last) begin
          unique case (phase_q)
            P_CROSS_S: s_q[tag2_q.dest] <= sat32(acc_d);
            P_CROSS_U: u_q[tag2_q.dest] <= sat32(acc_d);
            default:   t_q[tag2_q.dest] <= sat32(acc_d);
          endcase
        end
      end
    end
  end

  // Output register: one column group per transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (load) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ocol_q <= grp_q;
      ofin_q <= (grp_q == 2'd3);
      if (grp_q == 2'd3) begin
        oe0_q <= t_q[0];
        oe1_q <= t_q[1];
        oe2_q <= t_q[2];
        oe3_q <= 32'(64'd1 << FRAC_BITS);
      end else begin
        oe0_q <= s_q[grp_q];
        oe1_q <= u_q[grp_q];
        oe2_q <= f_q[grp_q];
        oe3_q <= '0;
      end
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.column_index = ocol_q;
  assign out_o.elem0        = oe0_q;
  assign out_o.elem1        = oe1_q;
  assign out_o.elem2        = oe2_q;
  assign out_o.elem3        = oe3_q;
  assign out_o.final_group  = ofin_q;

endmodule

[rtl/core/look_at_view_matrix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix: fixed-point look-at view matrix generator
// Turns an eye point, a target point and an up hint into the 4x4 view
// matrix, delivered as four column-major groups of four entries.
// ----------------------------------------------------------------------------
// Each accepted camera transaction yields four output transactions, groups
// 0 to 3 of the column-major matrix, the last one flagged by final_group.
// The input side takes a new transaction whenever its two-entry queue has
// room, so up to two cameras wait while a third is being computed and while
// finished groups wait in the output register. The execution side works on
// one camera at a time: it runs the bit-serial square root (32 iterations
// per normalization) and the bit-serial divider (32+FRAC_BITS iterations
// per normalized component), and sends the 27 products of the two
// normalizations, two cross products and three dot products through a
// single three-stage multiply-accumulate pipe, then emits the four groups.
// A vector of zero length skips its divisions and stays zero. All entries
// are signed with FRAC_BITS fraction bits and saturate at the 32-bit limits.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
  parameter int unsigned FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lav_in_if.sink    in_i,
  lav_out_if.source out_o
);
  import lav_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_pop;

  // Front: accepts transactions and forms the unnormalized forward vector.
  lav_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  // Back: normalizes, crosses, projects the eye and emits the matrix.
  lav_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .out_o        (out_o)
  );

  // The last group of a matrix is always the translation column.
  a_final_is_last_column: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.final_group |-> out_o.column_index == 2'd3
  ) else $error("final group flagged on a column other than the last");

  // Groups of one matrix follow each other without gaps and in order.
  a_groups_in_order: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.final_group |=>
      out_o.valid && out_o.column_index == $past(out_o.column_index) + 2'd1
  ) else $error("column groups of a matrix out of order");

  // A queued item is only taken while the queue holds one.
  a_pop_needs_item: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid
  ) else $error("back part took an item from an empty queue");

endmodule
